FILE: design/decimal_bcd_arithmetic_unit_macros.svh
// Assertion macros for the BCD arithmetic unit.
`ifndef DECIMAL_BCD_ARITHMETIC_UNIT_MACROS_SVH
`define DECIMAL_BCD_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define BAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define BAU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/bau_pkg.sv
package bau_pkg;
	localparam int Digits = 16;
	localparam int WordW = 64;
	localparam int UsedW = 4 * Digits;
	localparam int IdxW = (Digits > 1) ? $clog2(Digits) : 1;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_DIVZ  = 2'd2;
	localparam logic [1:0] ST_OVF   = 2'd3;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;       // capture operands
		logic cmp_step;   // compare one digit pair, top down
		logic add_step;   // add/sub one digit of acc with b (sub when sub)
		logic sub;        // subtract instead of add
		logic to_trial;   // write the digit to the trial word, not to acc
		logic chk_ovf;    // flag overflow on the carry out of this digit
		logic add_clr;    // clear carry before a digit pass
		logic mul_shift;  // take next a digit as row count, shift acc
		logic mul_dec;    // one addition of b done for this row
		logic div_shift;  // shift next a digit into remainder
		logic div_commit; // keep trial difference, bump quotient digit
		logic [IdxW-1:0] idx;
	} bau_cmd_t;

	typedef struct packed {
		logic a_lt_b;
		logic a_eq_b;
		logic b_zero;
		logic ovf;        // sum or product reached 10^Digits
		logic mdig_zero;  // no additions left in this multiply row
		logic div_ok;     // trial difference is not negative
	} bau_stat_t;

	function automatic logic [3:0] clean_digit(input logic [3:0] n);
		return (n > 4'd9) ? 4'd0 : n;
	endfunction
endpackage

FILE: design/bau_datapath.sv
module bau_datapath import bau_pkg::*; (
	input  logic              clk,
	input  logic [2:0]        req_type,
	input  logic [WordW-1:0]  operand_a,
	input  logic [WordW-1:0]  operand_b,
	input  bau_cmd_t          cmd,
	output bau_stat_t         stat,
	output logic [UsedW-1:0]  acc_out,
	output logic [UsedW-1:0]  quo_out
);
	logic [UsedW-1:0] a_q, b_q, acc_q, trial_q;
	logic             carry_q, lt_q, eq_q, ovf_q;
	logic [3:0]       mdig_q, rhi_q;
	logic [3:0]       da, db, dsum;
	logic [4:0]       raw;
	logic             cout;

	// One BCD digit of acc against the same digit of b.
	assign da = acc_q[4*cmd.idx +: 4];
	assign db = b_q[4*cmd.idx +: 4];
	always_comb begin
		if (cmd.sub) begin
			raw = {1'b0, da} - {1'b0, db} - {4'd0, carry_q};
			cout = raw[4];
			dsum = cout ? raw[3:0] + 4'd10 : raw[3:0];
		end else begin
			raw = {1'b0, da} + {1'b0, db} + {4'd0, carry_q};
			cout = (raw > 5'd9);
			dsum = cout ? 4'(raw - 5'd10) : raw[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < Digits; k++) begin
				a_q[4*k +: 4] <= clean_digit(operand_a[4*k +: 4]);
				b_q[4*k +: 4] <= clean_digit(operand_b[4*k +: 4]);
			end
			lt_q <= 1'b0; eq_q <= 1'b1; ovf_q <= 1'b0; carry_q <= 1'b0;
			rhi_q <= '0; mdig_q <= '0; trial_q <= '0;
			if (req_type == OP_ADD || req_type == OP_SUB) begin
				for (int k = 0; k < Digits; k++)
					acc_q[4*k +: 4] <= clean_digit(operand_a[4*k +: 4]);
			end else begin
				acc_q <= '0;
			end
		end else begin
			if (cmd.cmp_step && eq_q) begin
				if (a_q[4*cmd.idx +: 4] != b_q[4*cmd.idx +: 4]) begin
					eq_q <= 1'b0;
					lt_q <= (a_q[4*cmd.idx +: 4] < b_q[4*cmd.idx +: 4]);
				end
			end
			if (cmd.add_clr) carry_q <= 1'b0;
			if (cmd.add_step) begin
				carry_q <= cout;
				if (cmd.to_trial) trial_q[4*cmd.idx +: 4] <= dsum;
				else acc_q[4*cmd.idx +: 4] <= dsum;
				if (cmd.chk_ovf && cout) ovf_q <= 1'b1;
			end
			// multiply: one row per digit of a, top first
			if (cmd.mul_shift) begin
				mdig_q <= a_q[UsedW-4 +: 4];
				a_q <= {a_q[UsedW-5:0], 4'd0};
				if (acc_q[UsedW-4 +: 4] != 4'd0) ovf_q <= 1'b1;
				acc_q <= {acc_q[UsedW-5:0], 4'd0};
			end
			if (cmd.mul_dec) mdig_q <= mdig_q - 4'd1;
			// divide: the digit shifted out of acc stays as the remainder top
			if (cmd.div_shift) begin
				rhi_q <= acc_q[UsedW-4 +: 4];
				acc_q <= {acc_q[UsedW-5:0], a_q[UsedW-4 +: 4]};
				a_q <= {a_q[UsedW-5:0], 4'd0};
			end
			if (cmd.div_commit) begin
				acc_q <= trial_q;
				rhi_q <= rhi_q - {3'd0, carry_q};
				a_q[3:0] <= a_q[3:0] + 4'd1;
			end
		end
	end

	assign stat.a_lt_b    = lt_q;
	assign stat.a_eq_b    = eq_q;
	assign stat.b_zero    = (b_q == '0);
	assign stat.ovf       = ovf_q;
	assign stat.mdig_zero = (mdig_q == 4'd0);
	assign stat.div_ok    = !carry_q || (rhi_q != 4'd0);
	assign acc_out = acc_q;
	assign quo_out = a_q;
endmodule

FILE: design/bau_ctrl.sv
module bau_ctrl import bau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] req_type,
	input  bau_stat_t  stat,
	output logic       busy,
	output logic       done,
	output logic [2:0] op,
	output bau_cmd_t   cmd
);
	localparam logic [3:0] S_IDLE = 4'd0, S_CMP = 4'd1, S_ADD = 4'd2, S_SUB = 4'd3,
		S_MROW = 4'd4, S_MCHK = 4'd5, S_MADD = 4'd6, S_DSH = 4'd7, S_DTRY = 4'd8,
		S_DCHK = 4'd9, S_DONE = 4'd10;
	logic [3:0]      state_q;
	logic [IdxW-1:0] idx_q, row_q;
	logic [2:0]      op_q;
	logic            last;

	assign last = (idx_q == IdxW'(Digits - 1));
	assign busy = (state_q != S_IDLE);
	assign op = op_q;

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		unique case (state_q)
			S_IDLE: cmd.load = start;
			S_CMP:  begin cmd.cmp_step = 1'b1; cmd.idx = IdxW'(Digits - 1) - idx_q; end
			S_ADD:  begin cmd.add_step = 1'b1; cmd.chk_ovf = last; end
			S_SUB:  begin cmd.add_step = 1'b1; cmd.sub = 1'b1; end
			S_MROW: cmd.mul_shift = 1'b1;
			S_MCHK: cmd.add_clr = 1'b1;
			S_MADD: begin cmd.add_step = 1'b1; cmd.chk_ovf = last; cmd.mul_dec = last; end
			S_DSH:  begin cmd.div_shift = 1'b1; cmd.add_clr = 1'b1; end
			S_DTRY: begin cmd.add_step = 1'b1; cmd.sub = 1'b1; cmd.to_trial = 1'b1; end
			S_DCHK: begin cmd.div_commit = stat.div_ok; cmd.add_clr = 1'b1; end
			S_DONE: ;
			default: ;
		endcase
	end

	// Multiply: per a digit (top first) shift acc left and add b that many times.
	// Divide: per a digit shift it into the remainder and subtract b while it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; idx_q <= '0; row_q <= '0; op_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q <= req_type; idx_q <= '0; state_q <= S_CMP;
				end
				S_CMP: begin
					idx_q <= idx_q + 1'b1;
					if (last) begin
						idx_q <= '0; row_q <= '0;
						unique case (op_q)
							OP_ADD: state_q <= S_ADD;
							OP_SUB: state_q <= S_SUB;
							OP_MUL: state_q <= S_MROW;
							OP_DIV: state_q <= stat.b_zero ? S_DONE : S_DSH;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ADD, S_SUB: begin
					idx_q <= idx_q + 1'b1;
					if (last) begin
						idx_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_MROW: state_q <= S_MCHK;
				S_MCHK: begin
					idx_q <= '0;
					if (!stat.mdig_zero) state_q <= S_MADD;
					else if (row_q == IdxW'(Digits - 1)) state_q <= S_DONE;
					else begin row_q <= row_q + 1'b1; state_q <= S_MROW; end
				end
				S_MADD: begin
					idx_q <= idx_q + 1'b1;
					if (last) begin idx_q <= '0; state_q <= S_MCHK; end
				end
				S_DSH: begin idx_q <= '0; state_q <= S_DTRY; end
				S_DTRY: begin
					idx_q <= idx_q + 1'b1;
					if (last) begin idx_q <= '0; state_q <= S_DCHK; end
				end
				S_DCHK: begin
					if (stat.div_ok) state_q <= S_DTRY;
					else if (row_q == IdxW'(Digits - 1)) state_q <= S_DONE;
					else begin row_q <= row_q + 1'b1; state_q <= S_DSH; end
				end
				S_DONE: begin done <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/decimal_bcd_arithmetic_unit.sv
// From accept to result strobe: a digit-by-digit compare pass, then for add and subtract one
// digit-serial adder pass; multiply repeats that adder pass up to nine times per digit of a,
// and divide up to ten times per digit (nine kept differences and one that does not fit).
// Throughput: one word at a time; busy drops in the cycle of the result strobe.
// The result is presented for one cycle with done; the receiver cannot stall.
// Reset (arst_n low) returns the controller to idle and clears done.
`include "decimal_bcd_arithmetic_unit_macros.svh"
module decimal_bcd_arithmetic_unit import bau_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        req_type,
	input  logic [WordW-1:0]  operand_a,
	input  logic [WordW-1:0]  operand_b,
	output logic              done,
	output logic [WordW-1:0]  result_value,
	output logic              is_less,
	output logic              is_equal,
	output logic              is_greater,
	output logic [1:0]        status
);
	bau_cmd_t         cmd;
	bau_stat_t        stat;
	logic [2:0]       op;
	logic [UsedW-1:0] acc, quo;

	bau_ctrl u_ctrl (.clk, .arst_n, .start, .req_type, .stat, .busy, .done,
		.op, .cmd);
	bau_datapath u_dp (.clk, .req_type, .operand_a, .operand_b, .cmd, .stat,
		.acc_out(acc), .quo_out(quo));

	// Pick the result word and status from the finished datapath.
	always_comb begin
		result_value = '0;
		status = ST_OK;
		unique case (op)
			OP_ADD: begin result_value = WordW'(acc); if (stat.ovf) status = ST_OVF; end
			OP_SUB: if (stat.a_lt_b) status = ST_UNDER;
				else result_value = WordW'(acc);
			OP_MUL: begin result_value = WordW'(acc); if (stat.ovf) status = ST_OVF; end
			OP_DIV: if (stat.b_zero) status = ST_DIVZ;
				else result_value = WordW'(quo);
			default: ;
		endcase
	end
	assign is_less = stat.a_lt_b;
	assign is_equal = stat.a_eq_b;
	assign is_greater = !stat.a_lt_b && !stat.a_eq_b;

	`BAU_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`BAU_ASSERT_IMP(a_flags_one, clk, arst_n, done, $onehot({is_less, is_equal, is_greater}))
	`BAU_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
endmodule
